// ----- sv/mlp_sigmoid_forward_inference_assert.svh -----
// Assertion helpers for the sigmoid network block.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef MLP_SIGMOID_FORWARD_INFERENCE_ASSERT_SVH
`define MLP_SIGMOID_FORWARD_INFERENCE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define MSF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msf assertion failed");

// The consequent holds in the cycle after the antecedent.
`define MSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msf assertion failed");

`endif

// ----- sv/msf_pkg.sv -----
// ----------------------------------------------------------------------------
// msf_pkg
// Shared constants and control types of the sigmoid network block.
// ----------------------------------------------------------------------------
package msf_pkg;

  localparam int MAX_LAYERS_DEF      = 4;
  localparam int MAX_WIDTH_DEF       = 16;
  localparam int SIGMOID_ENTRIES_DEF = 256;

  // Number of layer width registers.
  localparam int NUM_WREGS = 4;
  localparam int ACC_W     = 40;
  localparam int FRAC_BITS = 12;

  // Configuration register indexes.
  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_INPUT_WIDTH = 3'd1;
  localparam logic [2:0] REG_WIDTH_L1    = 3'd2;
  localparam logic [2:0] REG_WIDTH_L2    = 3'd3;
  localparam logic [2:0] REG_WIDTH_L3    = 3'd4;
  localparam logic [2:0] REG_WIDTH_L4    = 3'd5;

  // Request types of an input transaction.
  localparam logic REQ_WEIGHT  = 1'b0;
  localparam logic REQ_ELEMENT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic w_we;     // write a weight word
    logic a_we;     // store an input element
    logic issue;    // start one multiply-accumulate
    logic acc_clr;  // clear the accumulator
    logic fin;      // activate the accumulator into the layer buffer
    logic copy;     // move the finished layer into the activation buffer
    logic first;    // reading from the input vector
  } cmd_t;

endpackage

// ----- sv/mlp_sigmoid_forward_inference.sv -----
// ----------------------------------------------------------------------------
// mlp_sigmoid_forward_inference
// Bias-free fully connected sigmoid network, forward pass in Q4.12.
// ----------------------------------------------------------------------------
// A weight write or a non-final element is taken while idle. The final element
// starts a pass (per neuron: a MAC per source, a drain and the sigmoid; a copy
// per layer), paced by the single multiply-accumulate unit and the one read
// port of the weight RAM; results then follow one per cycle while out_stall is low.
// Throughput: one vector at a time; inputs are stalled until the last result.
// Reset (synchronous, rst_n low) restores the control and configuration registers and idles the block.
// ----------------------------------------------------------------------------
module mlp_sigmoid_forward_inference import msf_pkg::*; #(
  parameter int MaxLayers      = MAX_LAYERS_DEF,
  parameter int MaxWidth       = MAX_WIDTH_DEF,
  parameter int SigmoidEntries = SIGMOID_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [1:0]         in_layer_sel,
  input  logic [3:0]         in_row_sel,
  input  logic [3:0]         in_col_sel,
  input  logic signed [15:0] in_data_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_index,
  output logic [12:0]        out_value,
  output logic               out_last
);

`include "mlp_sigmoid_forward_inference_assert.svh"

  localparam int IW = $clog2(MaxWidth);

  cmd_t          cmd;
  logic [1:0]    layer;
  logic [IW-1:0] row, col;
  logic          idle, pipe_busy;

  // The controller walks the layer, neuron and source loops; the datapath
  // only follows its commands and reports whether the MAC pipe is empty.
  msf_ctrl #(.MaxLayers(MaxLayers), .MaxWidth(MaxWidth)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_req_type  (in_req_type),
    .in_layer_sel (in_layer_sel),
    .in_row_sel   (in_row_sel),
    .in_col_sel   (in_col_sel),
    .idle         (idle),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .pipe_busy    (pipe_busy),
    .cmd          (cmd),
    .layer        (layer),
    .row          (row),
    .col          (col)
  );

  msf_dp #(
    .MaxLayers(MaxLayers), .MaxWidth(MaxWidth), .SigmoidEntries(SigmoidEntries)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .layer        (layer),
    .row          (row),
    .col          (col),
    .in_layer_sel (in_layer_sel),
    .in_row_sel   (in_row_sel),
    .in_col_sel   (in_col_sel),
    .in_data_word (in_data_word),
    .pipe_busy    (pipe_busy),
    .out_value    (out_value)
  );

  // A transaction is only taken while the sequencer is idle.
  assign in_stall  = !idle;
  assign out_index = 4'(row);

  // No input is taken while results are being delivered.
  `MSF_ASSERT_SAME(a_out_blocks_in, out_valid, in_stall)
  // The MAC pipe is empty whenever new input can be taken.
  `MSF_ASSERT_SAME(a_idle_pipe_empty, !in_stall, !pipe_busy)
  // The final result of a vector returns the block to idle.
  `MSF_ASSERT_NEXT(a_last_ends, out_valid && out_last && !out_stall, !out_valid && !in_stall)

endmodule

// ----- sv/msf_ram.sv -----
// ----------------------------------------------------------------------------
// msf_ram
// Generic one-write, one-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msf_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/msf_ctrl.sv -----
// ----------------------------------------------------------------------------
// msf_ctrl
// Sequencer: configuration, transaction acceptance and the layer/neuron loops.
// ----------------------------------------------------------------------------
module msf_ctrl import msf_pkg::*; #(
  parameter int MaxLayers = MAX_LAYERS_DEF,
  parameter int MaxWidth  = MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_addr,
  input  logic [4:0]                  cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_req_type,
  input  logic [1:0]                  in_layer_sel,
  input  logic [3:0]                  in_row_sel,
  input  logic [3:0]                  in_col_sel,
  output logic                        idle,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        out_last,
  input  logic                        pipe_busy,
  output cmd_t                        cmd,
  output logic [1:0]                  layer,
  output logic [$clog2(MaxWidth)-1:0] row,
  output logic [$clog2(MaxWidth)-1:0] col
);

  localparam int IW    = $clog2(MaxWidth);
  localparam int WW    = $clog2(MaxWidth + 1);
  localparam int LCMAX = (MaxLayers < NUM_WREGS) ? MaxLayers : NUM_WREGS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MAC    = 6'b000010,
    S_DRAIN  = 6'b000100,
    S_FINISH = 6'b001000,
    S_COPY   = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    lcount_r;
  logic [4:0]    iwidth_r;
  logic [4:0]    lwidth_r [NUM_WREGS];
  logic [1:0]    l_r, l_nxt;
  logic [IW-1:0] j_r, j_nxt, c_r, c_nxt;
  logic [WW-1:0] prev_r, prev_nxt, cur_r, cur_nxt;
  logic [2:0]    lc;
  logic [WW-1:0] iw;
  logic          accept, start;

  function automatic logic [WW-1:0] clamp_w(logic [4:0] w);
    if (w == 5'd0) begin
      return WW'(1);
    end else if (int'(w) > MaxWidth) begin
      return WW'(MaxWidth);
    end else begin
      return WW'(w);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcount_r <= 3'd2;
      iwidth_r <= 5'd16;
      for (int k = 0; k < NUM_WREGS; k++) begin
        lwidth_r[k] <= 5'd16;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LAYER_COUNT: lcount_r    <= cfg_wdata[2:0];
        REG_INPUT_WIDTH: iwidth_r    <= cfg_wdata;
        REG_WIDTH_L1:    lwidth_r[0] <= cfg_wdata;
        REG_WIDTH_L2:    lwidth_r[1] <= cfg_wdata;
        REG_WIDTH_L3:    lwidth_r[2] <= cfg_wdata;
        REG_WIDTH_L4:    lwidth_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lcount_r == 3'd0) begin
      lc = 3'd1;
    end else if (int'(lcount_r) > LCMAX) begin
      lc = 3'(LCMAX);
    end else begin
      lc = lcount_r;
    end
    iw = clamp_w(iwidth_r);
  end

  assign idle   = (state_r == S_IDLE);
  assign accept = idle && in_valid;
  assign start  = accept && (in_req_type == REQ_ELEMENT) && (int'(in_col_sel) < MaxWidth)
                  && (WW'(in_col_sel) == iw - WW'(1));

  always_comb begin
    state_nxt   = state_r;
    l_nxt       = l_r;
    j_nxt       = j_r;
    c_nxt       = c_r;
    prev_nxt    = prev_r;
    cur_nxt     = cur_r;
    cmd         = '0;
    cmd.first   = (l_r == 2'd0);
    cmd.w_we    = accept && (in_req_type == REQ_WEIGHT) && (int'(in_layer_sel) < MaxLayers)
                  && (int'(in_row_sel) < MaxWidth) && (int'(in_col_sel) < MaxWidth);
    cmd.a_we    = accept && (in_req_type == REQ_ELEMENT) && (int'(in_col_sel) < MaxWidth);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          l_nxt       = 2'd0;
          j_nxt       = '0;
          c_nxt       = '0;
          prev_nxt    = iw;
          cur_nxt     = clamp_w(lwidth_r[0]);
          cmd.acc_clr = 1'b1;
          state_nxt   = S_MAC;
        end
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (WW'(c_r) == prev_r - WW'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          c_nxt = c_r + IW'(1);
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.fin = 1'b1;
        if (WW'(j_r) == cur_r - WW'(1)) begin
          state_nxt = S_COPY;
        end else begin
          j_nxt       = j_r + IW'(1);
          c_nxt       = '0;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_MAC;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        j_nxt    = '0;
        c_nxt    = '0;
        if (3'(l_r) == lc - 3'd1) begin
          state_nxt = S_OUT;
        end else begin
          l_nxt       = l_r + 2'd1;
          prev_nxt    = cur_r;
          cur_nxt     = clamp_w(lwidth_r[l_r + 2'd1]);
          cmd.acc_clr = 1'b1;
          state_nxt   = S_MAC;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (WW'(j_r) == cur_r - WW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt = j_r + IW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      l_r     <= 2'd0;
      j_r     <= '0;
      c_r     <= '0;
      prev_r  <= WW'(1);
      cur_r   <= WW'(1);
    end else begin
      state_r <= state_nxt;
      l_r     <= l_nxt;
      j_r     <= j_nxt;
      c_r     <= c_nxt;
      prev_r  <= prev_nxt;
      cur_r   <= cur_nxt;
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_last  = (WW'(j_r) == cur_r - WW'(1));
  assign layer     = l_r;
  assign row       = j_r;
  assign col       = c_r;

endmodule

// ----- sv/msf_dp.sv -----
// ----------------------------------------------------------------------------
// msf_dp
// Datapath: weight store, activation buffer, MAC pipeline and sigmoid table.
// ----------------------------------------------------------------------------
module msf_dp import msf_pkg::*; #(
  parameter int MaxLayers      = MAX_LAYERS_DEF,
  parameter int MaxWidth       = MAX_WIDTH_DEF,
  parameter int SigmoidEntries = SIGMOID_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  input  logic [1:0]                  layer,
  input  logic [$clog2(MaxWidth)-1:0] row,
  input  logic [$clog2(MaxWidth)-1:0] col,
  input  logic [1:0]                  in_layer_sel,
  input  logic [3:0]                  in_row_sel,
  input  logic [3:0]                  in_col_sel,
  input  logic signed [15:0]          in_data_word,
  output logic                        pipe_busy,
  output logic [12:0]                 out_value
);

  localparam int IW  = $clog2(MaxWidth);
  localparam int AIW = $clog2(2 * MaxWidth);
  localparam int DEP = MaxLayers * MaxWidth * MaxWidth;
  localparam int AW  = $clog2(DEP);
  localparam int SIW = $clog2(SigmoidEntries);

  logic [12:0]             lut [SigmoidEntries];
  logic [15:0]             act_r [2 * MaxWidth];
  logic [12:0]             tmp_r [MaxWidth];
  logic [AW-1:0]           waddr, raddr;
  logic [15:0]             wdata_rd;
  logic signed [15:0]      a_r;
  logic signed [31:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r, shifted;
  logic                    v1_r, v2_r;
  logic [15:0]             sat;

  // Bin centers are (2*si+1)*8/SigmoidEntries with si the signed bin index.
  for (genvar g = 0; g < SigmoidEntries; g++) begin : g_lut
    localparam int  SI = (2 * g >= SigmoidEntries) ? g - SigmoidEntries : g;
    localparam real C  = 8.0 * real'(2 * SI + 1) / real'(SigmoidEntries);
    localparam real Q  = 4096.0 / (1.0 + $exp(-C));
    localparam int  E  = $rtoi(Q + 0.5);
    assign lut[g] = 13'(E);
  end

  assign waddr = AW'((AW'(in_layer_sel) * AW'(MaxWidth) + AW'(in_row_sel)) * AW'(MaxWidth)
                 + AW'(in_col_sel));
  assign raddr = AW'((AW'(layer) * AW'(MaxWidth) + AW'(row)) * AW'(MaxWidth) + AW'(col));

  msf_ram #(.Width(16), .Depth(DEP)) u_wram (
    .clk   (clk),
    .we    (cmd.w_we),
    .waddr (waddr),
    .wdata (in_data_word),
    .re    (cmd.issue),
    .raddr (raddr),
    .rdata (wdata_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.a_we) begin
      act_r[AIW'(in_col_sel)] <= in_data_word;
    end
    if (cmd.copy) begin
      for (int k = 0; k < MaxWidth; k++) begin
        act_r[MaxWidth + k] <= {3'b000, tmp_r[k]};
      end
    end
    if (cmd.issue) begin
      a_r <= act_r[cmd.first ? AIW'(col) : AIW'(MaxWidth) + AIW'(col)];
    end
    if (v1_r) begin
      prod_r <= $signed(wdata_rd) * a_r;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.fin) begin
      tmp_r[row] <= lut[sat[15 -: SIW]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  assign pipe_busy = v1_r || v2_r;
  assign shifted   = acc_r >>> FRAC_BITS;

  always_comb begin
    if (shifted > ACC_W'(32767)) begin
      sat = 16'h7FFF;
    end else if (shifted < -ACC_W'(32768)) begin
      sat = 16'h8000;
    end else begin
      sat = shifted[15:0];
    end
  end

  assign out_value = tmp_r[row];

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bias-free sigmoid network forward pass.
// ----------------------------------------------------------------------------
// A local fixed-point predictor follows every accepted input transaction. It
// keeps its own copy of the weights, the activations and the registers. When
// the last element of a vector is accepted, it queues the expected output
// neurons. A monitor compares each accepted output transaction field by field
// with the oldest queued expectation. Directed tests come first: extreme
// values and the register saturation cases. Random vectors then run under
// three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_top;
  import msf_pkg::*;

  typedef struct packed {
    logic [3:0]  index;
    logic [12:0] value;
    logic        last;
  } neuron_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_addr;
  logic [4:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic [1:0]         in_layer_sel;
  logic [3:0]         in_row_sel;
  logic [3:0]         in_col_sel;
  logic signed [15:0] in_data_word;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         out_index;
  logic [12:0]        out_value;
  logic               out_last;

  mlp_sigmoid_forward_inference uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_layer_sel (in_layer_sel),
    .in_row_sel   (in_row_sel),
    .in_col_sel   (in_col_sel),
    .in_data_word (in_data_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_index    (out_index),
    .out_value    (out_value),
    .out_last     (out_last)
  );

  // Predictor state: weights, activations, registers and the sigmoid table.
  logic signed [15:0] weight_mem [4][16][16];
  logic signed [15:0] act_mem [32];
  logic [2:0]         layers_reg;
  logic [4:0]         in_width_reg;
  logic [4:0]         layer_width_reg [4];
  logic [12:0]        sigmoid_lut [256];

  neuron_result_t     expected_neurons [$];
  int                 error_count;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every input is known from time zero.
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = REG_LAYER_COUNT;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_req_type  = REQ_WEIGHT;
    in_layer_sel = '0;
    in_row_sel   = '0;
    in_col_sel   = '0;
    in_data_word = '0;
    out_stall    = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sigmoid table, built in exact integer arithmetic. The exponential is a
  // Taylor series of exp(-m/(8N)) raised to the 64th power by six squarings,
  // all in Q62.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  function automatic longint unsigned exp_q62(longint unsigned m, longint unsigned n);
    longint unsigned top;
    longint unsigned y;
    longint unsigned term;
    longint unsigned sum;
    top  = 64'd1 << 59;
    y    = (top / n) * m + ((top % n) * m) / n;
    term = 64'd1 << 62;
    sum  = 64'd1 << 62;
    for (int k = 1; k <= 24; k++) begin
      term = mul_q62(term, y) / k;
      if (k % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    for (int s = 0; s < 6; s++) sum = mul_q62(sum, sum);
    return sum;
  endfunction

  function automatic logic [12:0] round_q12(longint unsigned num, longint unsigned den);
    longint unsigned rem;
    longint unsigned q;
    rem = num;
    q   = 0;
    for (int i = 0; i < 13; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 1;
      end
    end
    q = (q + 1) >> 1;
    return (q > 4096) ? 13'd4096 : q[12:0];
  endfunction

  task automatic build_sigmoid_lut();
    longint unsigned m;
    longint unsigned e;
    longint unsigned one;
    one = 64'd1 << 62;
    for (int i = 0; i < 256; i++) begin
      m = (i >= 128) ? 2 * (256 - i) - 1 : 2 * i + 1;
      e = exp_q62(m, 256);
      sigmoid_lut[i] = round_q12((i >= 128) ? e : one, one + e);
    end
  endtask

  function automatic int clamp_width(logic [4:0] w);
    if (w < 1) return 1;
    return (w > 16) ? 16 : int'(w);
  endfunction

  // One neuron: 40-bit sum of products, floor shift by 12, saturate to 16 bits,
  // then look up the sigmoid by the top 8 bits of the saturated value.
  function automatic logic [12:0] neuron_value(int layer, int row, int fan_in, int src);
    logic signed [39:0] acc;
    logic signed [39:0] shifted;
    logic [15:0]        sat;
    acc = '0;
    for (int c = 0; c < fan_in; c++)
      acc += 40'(weight_mem[layer][row][c]) * 40'(act_mem[src + c]);
    shifted = acc >>> 12;
    if (shifted > 40'sd32767)       sat = 16'h7FFF;
    else if (shifted < -40'sd32768) sat = 16'h8000;
    else                            sat = shifted[15:0];
    return sigmoid_lut[sat[15:8]];
  endfunction

  // Applies one accepted input transaction to the predictor state and queues
  // the output neurons when a vector is complete.
  task automatic predict_forward_pass(logic req, logic [1:0] lsel, logic [3:0] row,
                                      logic [3:0] col, logic signed [15:0] data);
    int             iw;
    int             nl;
    int             fan_in;
    int             src;
    int             w;
    logic [12:0]    layer_out [16];
    neuron_result_t r;
    if (req == REQ_WEIGHT) begin
      weight_mem[lsel][row][col] = data;
      return;
    end
    act_mem[col] = data;
    iw = clamp_width(in_width_reg);
    if (col != iw - 1) return;
    nl     = (layers_reg < 1) ? 1 : ((layers_reg > 4) ? 4 : int'(layers_reg));
    fan_in = iw;
    src    = 0;
    w      = 1;
    for (int l = 0; l < nl; l++) begin
      w = clamp_width(layer_width_reg[l]);
      for (int j = 0; j < w; j++) layer_out[j] = neuron_value(l, j, fan_in, src);
      for (int j = 0; j < w; j++) act_mem[16 + j] = layer_out[j];
      src    = 16;
      fan_in = w;
    end
    for (int j = 0; j < w; j++) begin
      r.index = j[3:0];
      r.value = layer_out[j];
      r.last  = (j == w - 1);
      expected_neurons = {expected_neurons, r};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. All inputs change by nonblocking assignment at the rising edge.
  // A transaction is taken at the first edge where in_stall is seen low.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic req, logic [1:0] lsel, logic [3:0] row,
                           logic [3:0] col, logic signed [15:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_layer_sel <= lsel;
    in_row_sel   <= row;
    in_col_sel   <= col;
    in_data_word <= data;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_forward_pass(req, lsel, row, col, data);
  endtask

  // Drops valid in the step of the last acceptance, then waits for every
  // expected neuron plus a short margin, so the block is idle for a write.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_neurons.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [4:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_LAYER_COUNT: layers_reg   = val[2:0];
      REG_INPUT_WIDTH: in_width_reg = val;
      REG_WIDTH_L1:    layer_width_reg[0] = val;
      REG_WIDTH_L2:    layer_width_reg[1] = val;
      REG_WIDTH_L3:    layer_width_reg[2] = val;
      REG_WIDTH_L4:    layer_width_reg[3] = val;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(logic [4:0] nl, logic [4:0] iw, logic [4:0] w1,
                                logic [4:0] w2, logic [4:0] w3, logic [4:0] w4);
    write_reg(REG_LAYER_COUNT, nl);
    write_reg(REG_INPUT_WIDTH, iw);
    write_reg(REG_WIDTH_L1, w1);
    write_reg(REG_WIDTH_L2, w2);
    write_reg(REG_WIDTH_L3, w3);
    write_reg(REG_WIDTH_L4, w4);
  endtask

  // Mostly moderate Q4.12 values, so the sums spread over the sigmoid, with a
  // share of full-range words that drive the saturation.
  function automatic logic signed [15:0] rand_word();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(4095)) - 2048);
  endfunction

  // Sends elements 0..iw-1 with the final one last; the others may be shuffled.
  task automatic send_vector(int iw, bit shuffle);
    int order [$];
    for (int i = 0; i < iw - 1; i++) order = {order, i};
    if (shuffle) order.shuffle();
    order = {order, iw - 1};
    foreach (order[i])
      send_item(REQ_ELEMENT, 2'($urandom), 4'($urandom), 4'(order[i]), rand_word());
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor and receiver stall generator.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    neuron_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_neurons.size() == 0) begin
        report_mismatch("unexpected output neuron, index", out_index, -1);
      end else begin
        want = expected_neurons.pop_front();
        if (out_index !== want.index) report_mismatch("out_index", out_index, want.index);
        if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
        if (out_last !== want.last)   report_mismatch("out_last", out_last, want.last);
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Each layer gets its 4x4 corner plus one full line: row 0 in even layers,
  // column 0 in odd layers. Every network used below reads only inside these,
  // so no unwritten weight is ever read. Extreme words sit in layer 0.
  task automatic test_weight_load();
    logic signed [15:0] w;
    for (int l = 0; l < 4; l++)
      for (int r = 0; r < 16; r++)
        for (int c = 0; c < 16; c++) begin
          if ((r < 4 && c < 4) || (l % 2 == 0 && r == 0) || (l % 2 == 1 && c == 0)) begin
            w = rand_word();
            if (l == 0 && r == 0 && c == 0) w = 16'sh7FFF;
            if (l == 0 && r == 3 && c == 3) w = 16'sh8000;
            send_item(REQ_WEIGHT, 2'(l), 4'(r), 4'(c), w);
          end
        end
  endtask

  // Under the reset register values a vector is sixteen elements long, so
  // fifteen elements with the largest, smallest and zero values start no pass.
  task automatic test_reset_vector();
    logic signed [15:0] e;
    for (int i = 0; i < 15; i++) begin
      case (i % 4)
        0: e = 16'sh7FFF;
        1: e = 16'sh8000;
        2: e = 16'sh0000;
        default: e = rand_word();
      endcase
      send_item(REQ_ELEMENT, 2'(i % 4), 4'(15 - i), 4'(i), e);
    end
    wait_for_idle();
  endtask

  // Smallest network, register saturation at both ends, an element past the
  // vector end, and an out-of-order vector.
  task automatic test_register_limits();
    write_all_regs(5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1);
    send_item(REQ_ELEMENT, 2'd3, 4'd15, 4'd0, 16'sh7FFF);
    send_item(REQ_ELEMENT, 2'd0, 4'd0, 4'd0, 16'sh8000);
    wait_for_idle();
    // Zero counts read as one; a vector of width one triggers at once.
    write_all_regs(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    send_item(REQ_ELEMENT, 2'd0, 4'd0, 4'd0, 16'sh1000);
    wait_for_idle();
    // Counts above the maximum read as four layers and widths of sixteen;
    // the single-neuron layers in between keep the reads on the full lines.
    write_all_regs(5'd7, 5'd31, 5'd1, 5'd31, 5'd1, 5'd20);
    send_vector(16, 1'b1);
    wait_for_idle();
    write_all_regs(5'd3, 5'd4, 5'd2, 5'd4, 5'd3, 5'd5);
    send_item(REQ_ELEMENT, 2'd1, 4'd1, 4'd9, 16'sh0ABC);   // beyond width: no pass
    send_item(REQ_WEIGHT, 2'd2, 4'd1, 4'd15, 16'sh8000);
    send_vector(4, 1'b1);
    wait_for_idle();
  endtask

  // Random register settings within the written 4x4 corners and vectors with
  // weight writes and stray elements mixed in, until about item_budget
  // transactions have gone in.
  task automatic test_random_vectors(int idle_pct, int stall_pct, int item_budget);
    int sent;
    int iw;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < item_budget) begin
      wait_for_idle();
      write_all_regs(5'($urandom_range(($urandom_range(7) == 0) ? 7 : 4)),
                     5'($urandom_range(4)),
                     5'($urandom_range(4)), 5'($urandom_range(4)),
                     5'($urandom_range(4)), 5'($urandom_range(4)));
      iw = clamp_width(in_width_reg);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 2)) begin
          send_item(REQ_WEIGHT, 2'($urandom), 4'($urandom), 4'($urandom), rand_word());
          sent++;
        end
        if (iw < 16 && $urandom_range(4) == 0) begin
          send_item(REQ_ELEMENT, 2'($urandom), 4'($urandom),
                    4'($urandom_range(iw, 15)), rand_word());
          sent++;
        end
        send_vector(iw, $urandom_range(1));
        sent += iw;
      end
    end
    wait_for_idle();
  endtask

  initial begin
    error_count    = 0;
    send_idle_pct  = 12;
    recv_stall_pct = 85;
    layers_reg     = 3'd2;
    in_width_reg   = 5'd16;
    for (int i = 0; i < 4; i++) layer_width_reg[i] = 5'd16;
    for (int i = 0; i < 32; i++) act_mem[i] = '0;
    build_sigmoid_lut();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_weight_load();
    test_reset_vector();
    test_register_limits();
    test_random_vectors(12, 85, 16);
    test_random_vectors(85, 12, 16);
    test_random_vectors(0, 0, 16);

    repeat (50) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog well above the slowest legal run.
  initial begin
    #(20 * 400000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
